// File: hw/rtl/iht_pkg.sv
// ----------------------------------------------------------------------------
// iht_pkg
// Types, constants and helpers shared by the IP host table modules.
// ----------------------------------------------------------------------------
package iht_pkg;

  localparam int BUCKETS  = 256;
  localparam int WAYS     = 4;
  localparam int BUCKET_W = $clog2(BUCKETS);
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int IP_W     = 32;
  localparam int IDX_W    = 10;
  localparam int CNT_W    = 11;
  localparam int RM_W     = $clog2(WAYS + 1);
  localparam int IDX_CALC_W = BUCKET_W + WAY_W + 1;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [BUCKET_W-1:0] LAST_BUCKET = BUCKET_W'(BUCKETS - 1);

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_CREATE = 2'd1,
    OP_DELETE = 2'd2,
    OP_AGE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPD,
    ST_AGE
  } state_t;

  typedef struct packed {
    logic            valid;
    logic            online;
    logic [IP_W-1:0] ip;
  } entry_t;

  typedef entry_t [WAYS-1:0] row_t;

  typedef struct packed {
    logic                en;
    logic [BUCKET_W-1:0] addr;
    row_t                data;
  } mem_wr_t;

  function automatic logic [BUCKET_W-1:0] bucket_of(input logic [IP_W-1:0] ip);
    logic [7:0] b;
    b = ip[7:0] ^ ip[15:8];
    return b[BUCKET_W-1:0];
  endfunction

endpackage

// File: hw/rtl/iht_store.sv
// ----------------------------------------------------------------------------
// iht_store
// Bucket memory, one row of ways per bucket, with per-row valid flops so
// that rows not written since reset read as empty.
// ----------------------------------------------------------------------------
module iht_store (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [iht_pkg::BUCKET_W-1:0]  rd_addr,
  output iht_pkg::row_t                 rd_row,
  input  iht_pkg::mem_wr_t              wr
);
  import iht_pkg::*;

  row_t               mem [BUCKETS];
  logic [BUCKETS-1:0] row_valid;
  row_t               rd_q;
  logic               rd_ok;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_ok     <= 1'b0;
    end else begin
      if (wr.en) begin
        row_valid[wr.addr] <= 1'b1;
      end
      rd_ok <= row_valid[rd_addr];
    end
  end

  assign rd_row = rd_ok ? rd_q : '0;

endmodule

// File: hw/rtl/iht_ctrl.sv
// ----------------------------------------------------------------------------
// iht_ctrl
// Command sequencer: reads a bucket, matches and updates its ways, writes
// the row back and reports the result; walks all buckets for an age sweep.
// ----------------------------------------------------------------------------
module iht_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    opcode,
  input  logic [iht_pkg::IP_W-1:0]      host_ip,
  output logic                          done,
  output logic                          hit,
  output logic                          created,
  output logic                          no_room,
  output logic [iht_pkg::IDX_W-1:0]     entry_index,
  output logic [iht_pkg::CNT_W-1:0]     removed_count,
  output logic [iht_pkg::BUCKET_W-1:0]  rd_addr,
  input  iht_pkg::row_t                 rd_row,
  output iht_pkg::mem_wr_t              wr
);
  import iht_pkg::*;

  state_t              state, state_next;
  op_t                 op_q, op_next;
  logic [IP_W-1:0]     ip_q, ip_next;
  logic [BUCKET_W-1:0] sweep_row, sweep_row_next;
  logic [CNT_W-1:0]    acc, acc_next;

  logic                done_next, hit_next, created_next, no_room_next;
  logic [IDX_W-1:0]    index_next;
  logic [CNT_W-1:0]    count_next;

  logic [BUCKET_W-1:0] bucket_q;
  logic                found, free_found;
  logic [WAY_W-1:0]    found_way, free_way;
  row_t                upd_row, age_row;
  logic [RM_W-1:0]     rm;
  logic [CNT_W:0]      sum;
  logic [CNT_W-1:0]    sum_sat;
  logic [IDX_CALC_W-1:0] idx_found, idx_free;

  assign bucket_q = bucket_of(ip_q);
  assign busy     = (state != ST_IDLE);

  // way match and lowest free way
  always_comb begin
    found      = 1'b0;
    free_found = 1'b0;
    found_way  = '0;
    free_way   = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!found && rd_row[w].valid && rd_row[w].ip == ip_q) begin
        found     = 1'b1;
        found_way = WAY_W'(w);
      end
      if (!free_found && !rd_row[w].valid) begin
        free_found = 1'b1;
        free_way   = WAY_W'(w);
      end
    end
  end

  assign idx_found = IDX_CALC_W'(bucket_q) * IDX_CALC_W'(WAYS) + IDX_CALC_W'(found_way);
  assign idx_free  = IDX_CALC_W'(bucket_q) * IDX_CALC_W'(WAYS) + IDX_CALC_W'(free_way);

  // row after a lookup, create or delete
  always_comb begin
    upd_row = rd_row;
    if (found) begin
      if (op_q == OP_CREATE) begin
        upd_row[found_way].online = 1'b1;
      end else if (op_q == OP_DELETE) begin
        upd_row[found_way] = '0;
      end
    end else if (op_q == OP_CREATE && free_found) begin
      upd_row[free_way].valid  = 1'b1;
      upd_row[free_way].online = 1'b1;
      upd_row[free_way].ip     = ip_q;
    end
  end

  // row after an age pass
  always_comb begin
    age_row = rd_row;
    rm      = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (rd_row[w].valid) begin
        if (!rd_row[w].online) begin
          age_row[w] = '0;
          rm         = rm + RM_W'(1);
        end else begin
          age_row[w].online = 1'b0;
        end
      end
    end
  end

  assign sum     = {1'b0, acc} + (CNT_W+1)'(rm);
  assign sum_sat = (sum > (CNT_W+1)'(CNT_MAX)) ? CNT_MAX : sum[CNT_W-1:0];

  always_comb begin
    state_next     = state;
    op_next        = op_q;
    ip_next        = ip_q;
    sweep_row_next = sweep_row;
    acc_next       = acc;
    done_next      = 1'b0;
    hit_next       = 1'b0;
    created_next   = 1'b0;
    no_room_next   = 1'b0;
    index_next     = '0;
    count_next     = '0;
    rd_addr        = bucket_q;
    wr             = '0;
    unique case (state)
      ST_IDLE: begin
        rd_addr = (op_t'(opcode) == OP_AGE) ? '0 : bucket_of(host_ip);
        if (start) begin
          op_next        = op_t'(opcode);
          ip_next        = host_ip;
          sweep_row_next = '0;
          acc_next       = '0;
          state_next     = (op_t'(opcode) == OP_AGE) ? ST_AGE : ST_UPD;
        end
      end
      ST_UPD: begin
        wr.en        = 1'b1;
        wr.addr      = bucket_q;
        wr.data      = upd_row;
        done_next    = 1'b1;
        hit_next     = found;
        created_next = !found && op_q == OP_CREATE && free_found;
        no_room_next = !found && op_q == OP_CREATE && !free_found;
        if (found) begin
          index_next = idx_found[IDX_W-1:0];
        end else if (op_q == OP_CREATE && free_found) begin
          index_next = idx_free[IDX_W-1:0];
        end
        state_next = ST_IDLE;
      end
      ST_AGE: begin
        rd_addr        = sweep_row + BUCKET_W'(1);
        wr.en          = 1'b1;
        wr.addr        = sweep_row;
        wr.data        = age_row;
        acc_next       = sum_sat;
        sweep_row_next = sweep_row + BUCKET_W'(1);
        if (sweep_row == LAST_BUCKET) begin
          done_next  = 1'b1;
          count_next = sum_sat;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    op_q          <= op_next;
    ip_q          <= ip_next;
    sweep_row     <= sweep_row_next;
    acc           <= acc_next;
    hit           <= hit_next;
    created       <= created_next;
    no_room       <= no_room_next;
    entry_index   <= index_next;
    removed_count <= count_next;
  end

  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_UPD || (state == ST_AGE && sweep_row == LAST_BUCKET)))
    else $error("result beat without a finishing state");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> $onehot0({hit, created, no_room}))
    else $error("conflicting result flags");

  a_count_sweep_only: assert property (@(posedge clk) disable iff (rst)
    done && (hit || created || no_room) |-> removed_count == '0)
    else $error("removed count on a non-sweep beat");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> busy)
    else $error("row write while idle");

endmodule

// File: hw/rtl/ip_host_table_with_aging_top.sv
// ----------------------------------------------------------------------------
// ip_host_table_with_aging_top
// Set-associative IPv4 host table with lookup, create, delete and a single-pass
// age sweep over a synchronous bucket memory.
//
//   channel   handshake       payload
//   command   start / busy    opcode, host_ip
//   result    done strobe     hit, created, no_room, entry_index,
//                             removed_count
//
// lookup, create and delete read the bucket row from memory, then match,
// update and write the row back; the next command may start the cycle
// after the write.
// age sweep reads and writes one row per cycle.
// result beat appears the cycle after the write; the receiver cannot stall.
// reset clears the per-row valid flops at once, no clearing pass.
// ----------------------------------------------------------------------------
module ip_host_table_with_aging_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    opcode,
  input  logic [iht_pkg::IP_W-1:0]      host_ip,
  output logic                          done,
  output logic                          hit,
  output logic                          created,
  output logic                          no_room,
  output logic [iht_pkg::IDX_W-1:0]     entry_index,
  output logic [iht_pkg::CNT_W-1:0]     removed_count
);
  import iht_pkg::*;

  logic [BUCKET_W-1:0] rd_addr;
  row_t                rd_row;
  mem_wr_t             wr;

  iht_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_row  (rd_row),
    .wr      (wr)
  );

  iht_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .opcode        (opcode),
    .host_ip       (host_ip),
    .done          (done),
    .hit           (hit),
    .created       (created),
    .no_room       (no_room),
    .entry_index   (entry_index),
    .removed_count (removed_count),
    .rd_addr       (rd_addr),
    .rd_row        (rd_row),
    .wr            (wr)
  );

endmodule
